// ===== rtl/bgcd_pkg.sv =====
// Shared types and codes for the button gesture command decoder.
// No dependencies; every other file imports this package.
package bgcd_pkg;

  localparam int TimeoutWidth = 16;
  localparam int TargetWidth  = 4;
  localparam int IndexWidth   = 3;
  localparam int TimeWidth    = 32;
  localparam int CmdWidth     = 3;
  localparam int CfgDataWidth = 16;
  localparam int CfgIdxWidth  = 2;

  localparam logic [TargetWidth-1:0] TallyMax = 4'd15;

  // Register reset values
  localparam logic [TimeoutWidth-1:0] TimeoutReset = 16'd1500;
  localparam logic [TargetWidth-1:0]  TargetReset  = 4'd3;
  localparam logic [IndexWidth-1:0]   NextReset    = 3'd7;
  localparam logic [IndexWidth-1:0]   PrevReset    = 3'd0;

  // Register indexes
  localparam logic [CfgIdxWidth-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_TARGET  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_NEXT    = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_PREV    = 2'd3;

  // Item function codes
  localparam logic FUNC_SAMPLE  = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  typedef enum logic [CmdWidth-1:0] {
    GEST_NONE    = 3'd0,
    GEST_VIEW    = 3'd1,
    GEST_SET     = 3'd2,
    GEST_NEXT    = 3'd3,
    GEST_PREV    = 3'd4,
    GEST_INVALID = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [TimeoutWidth-1:0] timeout_ms;
    logic [TargetWidth-1:0]  multi_click_target;
    logic [IndexWidth-1:0]   next_index;
    logic [IndexWidth-1:0]   prev_index;
  } cfg_t;

  typedef struct packed {
    cmd_t command;
    logic complete;
  } res_t;

endpackage

// ===== rtl/bgcd_in_if.sv =====
// Input channel: button sample transaction with valid/ready handshake.
// Depends on bgcd_pkg for field widths.
interface bgcd_in_if import bgcd_pkg::*; #(
  parameter int BUTTON_COUNT = 8
);
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [BUTTON_COUNT-1:0] buttons;
  logic                    long_press;
  logic [TimeWidth-1:0]    now_ms;

  modport source (output valid, func, buttons, long_press, now_ms, input ready);
  modport sink   (input valid, func, buttons, long_press, now_ms, output ready);
endinterface

// ===== rtl/bgcd_out_if.sv =====
// Output channel: decoded command transaction with valid/ready handshake.
// Depends on bgcd_pkg for field widths.
interface bgcd_out_if import bgcd_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CmdWidth-1:0] command;
  logic                complete;

  modport source (output valid, command, complete, input ready);
  modport sink   (input valid, command, complete, output ready);
endinterface

// ===== rtl/bgcd_cfg.sv =====
// Configuration register file for the gesture decoder.
// Depends on bgcd_pkg (cfg_t, register indexes, reset values).
module bgcd_cfg import bgcd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_wdata,
  output cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms         <= TimeoutReset;
      cfg.multi_click_target <= TargetReset;
      cfg.next_index         <= NextReset;
      cfg.prev_index         <= PrevReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT: cfg.timeout_ms         <= cfg_wdata[TimeoutWidth-1:0];
        REG_TARGET:  cfg.multi_click_target <= cfg_wdata[TargetWidth-1:0];
        REG_NEXT:    cfg.next_index         <= cfg_wdata[IndexWidth-1:0];
        REG_PREV:    cfg.prev_index         <= cfg_wdata[IndexWidth-1:0];
        default:     ;
      endcase
    end
  end

endmodule

// ===== rtl/bgcd_core.sv =====
// Sequence state and single-pass update for one button sample.
// Depends on bgcd_pkg (cfg_t, res_t, cmd_t, function codes).
module bgcd_core import bgcd_pkg::*; #(
  parameter int BUTTON_COUNT = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    fire,
  input  logic                    func,
  input  logic [BUTTON_COUNT-1:0] buttons,
  input  logic                    long_press,
  input  logic [TimeWidth-1:0]    now_ms,
  output res_t                    result
);

  localparam logic [BUTTON_COUNT-1:0] One = {{(BUTTON_COUNT-1){1'b0}}, 1'b1};

  logic [BUTTON_COUNT-1:0] held_mask, held_mask_next;
  logic [BUTTON_COUNT-1:0] clicked_mask, clicked_mask_next;
  logic [TargetWidth-1:0]  click_tally, click_tally_next;
  logic                    done_flag, done_flag_next;
  logic [TimeWidth-1:0]    press_time, press_time_next;
  cmd_t                    current_command, current_command_next;

  logic [BUTTON_COUNT-1:0] next_hot, prev_hot, multi, lowest;
  logic [TargetWidth-1:0]  tally_inc;
  logic [TimeWidth-1:0]    elapsed;
  logic                    many_bad, right_bad, repeat_bad, hold_bad, sample_ok;
  logic                    is_multi;

  // Shifting past the top bit leaves zero, which drops out-of-range indexes
  assign next_hot = One << cfg.next_index;
  assign prev_hot = One << cfg.prev_index;
  assign multi    = next_hot | prev_hot;
  assign is_multi = |(buttons & multi);
  assign lowest   = clicked_mask & (~clicked_mask + One);

  assign many_bad   = |(buttons & (buttons - One));
  assign right_bad  = (|clicked_mask) && (|buttons) && (buttons > lowest);
  assign repeat_bad = (|(clicked_mask & buttons)) &&
                      (!is_multi || (|(clicked_mask & (clicked_mask - One))));
  assign hold_bad   = (|held_mask) && (|buttons) && (held_mask != buttons);
  assign sample_ok  = !(many_bad || right_bad || repeat_bad || hold_bad);

  assign tally_inc = (click_tally == TallyMax) ? click_tally
                                               : click_tally + TargetWidth'(1);
  assign elapsed   = now_ms - press_time;

  always_comb begin
    held_mask_next       = held_mask;
    clicked_mask_next    = clicked_mask;
    click_tally_next     = click_tally;
    done_flag_next       = done_flag;
    press_time_next      = press_time;
    current_command_next = current_command;
    if (func == FUNC_RESTART) begin
      held_mask_next       = '0;
      clicked_mask_next    = '0;
      click_tally_next     = '0;
      done_flag_next       = 1'b0;
      press_time_next      = '0;
      current_command_next = GEST_NONE;
    end else if (done_flag) begin
      // latched: hold everything
    end else if (press_time == '0) begin
      if (|buttons) press_time_next = now_ms;
    end else if (!sample_ok) begin
      current_command_next = GEST_INVALID;
    end else if (|buttons) begin
      if (held_mask == '0) begin
        press_time_next = now_ms;
        held_mask_next  = buttons;
        if (is_multi) begin
          click_tally_next = tally_inc;
          if (tally_inc == cfg.multi_click_target) begin
            current_command_next = (buttons == next_hot) ? GEST_NEXT : GEST_PREV;
          end
        end else begin
          click_tally_next = TargetWidth'(1);
        end
      end else if (long_press) begin
        current_command_next = GEST_SET;
      end
    end else begin
      // release: merge the held press into the clicked set
      clicked_mask_next = clicked_mask | held_mask;
      held_mask_next    = '0;
      if (current_command != GEST_NONE) begin
        done_flag_next = 1'b1;
      end else if (elapsed > {{(TimeWidth-TimeoutWidth){1'b0}}, cfg.timeout_ms}) begin
        current_command_next = GEST_VIEW;
        done_flag_next       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_mask       <= '0;
      clicked_mask    <= '0;
      click_tally     <= '0;
      done_flag       <= 1'b0;
      press_time      <= '0;
      current_command <= GEST_NONE;
    end else if (fire) begin
      held_mask       <= held_mask_next;
      clicked_mask    <= clicked_mask_next;
      click_tally     <= click_tally_next;
      done_flag       <= done_flag_next;
      press_time      <= press_time_next;
      current_command <= current_command_next;
    end
  end

  assign result.command  = current_command_next;
  assign result.complete = done_flag_next;

endmodule

// ===== rtl/button_gesture_command_decoder.sv =====
// Button gesture command decoder, top level.
// Path from input transaction to result: input register, then result register.
// Throughput: one transaction per cycle while result.ready is high; the sequence state update is a single
// combinational pass from the input register into the state and result registers.
// Reset (synchronous, rst high): clears state and the valid bits of both pipeline registers,
// loads register defaults (timeout 1500 ms, target 3, NEXT bit 7, PREV bit 0).
module button_gesture_command_decoder import bgcd_pkg::*; #(
  parameter int BUTTON_COUNT = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  bgcd_in_if.sink                 sample,
  bgcd_out_if.source              result,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_wdata
);

  cfg_t cfg;
  res_t core_res;

  // Input register
  logic                    in_valid;
  logic                    in_func;
  logic [BUTTON_COUNT-1:0] in_buttons;
  logic                    in_long_press;
  logic [TimeWidth-1:0]    in_now_ms;

  // Result register
  logic out_valid;
  res_t out_res;

  logic advance;

  // Advance the input register into the result register when the result
  // slot is empty or its transaction is being taken this cycle.
  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  // Capture the payload with every accepted transaction
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_func       <= sample.func;
      in_buttons    <= sample.buttons;
      in_long_press <= sample.long_press;
      in_now_ms     <= sample.now_ms;
    end
  end

  bgcd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // State commits only when the item moves on, so each item sees the state
  // left by the one before it.
  bgcd_core #(.BUTTON_COUNT(BUTTON_COUNT)) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fire       (advance),
    .func       (in_func),
    .buttons    (in_buttons),
    .long_press (in_long_press),
    .now_ms     (in_now_ms),
    .result     (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign result.valid    = out_valid;
  assign result.command  = out_res.command;
  assign result.complete = out_res.complete;

endmodule
